// ===== hw/rtl/mtg_pkg.sv =====
// Shared constants and types for the Mersenne Twister generator.
package mtg_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned STATE_WORDS = 624;
  localparam int unsigned TAP_OFFSET  = 397;
  localparam int unsigned DRAW_W      = 8;

  typedef logic [WORD_W-1:0] word_t;

  localparam word_t SEED_RESET   = 32'd5489;
  localparam word_t SEED_MULT    = 32'd1812433253;
  localparam word_t TWIST_VECTOR = 32'h9908_b0df;
  localparam word_t UPPER_MASK   = 32'h8000_0000;
  localparam word_t LOWER_MASK   = 32'h7fff_ffff;
  localparam word_t TEMPER_B     = 32'h9d2c_5680;
  localparam word_t TEMPER_C     = 32'hefc6_0000;

endpackage

// ===== hw/rtl/mtg_cell.sv =====
// One state word of the twister chain; loads its input word on each step.
module mtg_cell (
  input  logic          clk_i,
  input  logic          shift_i,
  input  mtg_pkg::word_t word_i,
  output mtg_pkg::word_t word_o
);

  mtg_pkg::word_t word_q;

  // Payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      word_q <= word_i;
    end
  end

  assign word_o = word_q;

endmodule

// ===== hw/rtl/mtg_seed.sv =====
// Seeding recurrence: next fill word from the last word pushed into the chain, or the seed for the first word.
module mtg_seed #(
  parameter int unsigned IdxW = 10
) (
  input  mtg_pkg::word_t  seed_i,
  input  mtg_pkg::word_t  prev_i,
  input  logic [IdxW-1:0] idx_i,
  output mtg_pkg::word_t  fill_o
);

  mtg_pkg::word_t mix;
  mtg_pkg::word_t prod;
  mtg_pkg::word_t idx_ext;

  // w[i] = mult * (w[i-1] ^ (w[i-1] >> 30)) + i, low 32 bits kept
  always_comb begin
    mix     = prev_i ^ (prev_i >> 30);
    prod    = mtg_pkg::word_t'(mix * mtg_pkg::SEED_MULT);
    idx_ext = {{(mtg_pkg::WORD_W-IdxW){1'b0}}, idx_i};
    fill_o  = (idx_i == '0) ? seed_i : prod + idx_ext;
  end

endmodule

// ===== hw/rtl/mtg_twist.sv =====
// Twist of one state word and tempering of the result.
module mtg_twist (
  input  mtg_pkg::word_t head_i,
  input  mtg_pkg::word_t next_i,
  input  mtg_pkg::word_t tap_i,
  output mtg_pkg::word_t word_o,
  output mtg_pkg::word_t temper_o
);

  mtg_pkg::word_t y;
  mtg_pkg::word_t v;
  mtg_pkg::word_t t0;
  mtg_pkg::word_t t1;
  mtg_pkg::word_t t2;

  // New state word from head, its successor and the tap
  always_comb begin
    y = (head_i & mtg_pkg::UPPER_MASK) | (next_i & mtg_pkg::LOWER_MASK);
    v = tap_i ^ (y >> 1);
    if (y[0]) begin
      v = v ^ mtg_pkg::TWIST_VECTOR;
    end
    word_o = v;
  end

  // Tempering
  always_comb begin
    t0       = v ^ (v >> 11);
    t1       = t0 ^ ((t0 << 7) & mtg_pkg::TEMPER_B);
    t2       = t1 ^ ((t1 << 15) & mtg_pkg::TEMPER_C);
    temper_o = t2 ^ (t2 >> 18);
  end

endmodule

// ===== hw/rtl/mersenne_twister_generator.sv =====
// Top level of the MT19937 generator: cell chain, fill sequencer and output register.
//
//  channel | dir | handshake                       | content
//  --------+-----+---------------------------------+----------------------------
//  s_axis  | in  | s_axis_tvalid_i/s_axis_tready_o | draw request, tdata[0]
//  m_axis  | out | m_axis_tvalid_o/m_axis_tready_i | tempered 32-bit word
//  seed    | in  | seed_we_i                       | seed value, no read-back
//
// In run mode a draw is taken every cycle; its word is in the output register the
// next cycle, computed from chain cells 0, 1 and TapOffset while the chain steps once.
// After reset and after every seed write the chain is filled through its tail cell,
// one word per cycle, StateWords (624) words in all; no draw is taken meanwhile.
// A stalled output register holds its word and blocks further draws until taken.
// A transfer with tdata[0] low is consumed and produces no word.
module mersenne_twister_generator #(
  parameter int unsigned StateWords = mtg_pkg::STATE_WORDS,
  parameter int unsigned TapOffset  = mtg_pkg::TAP_OFFSET
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // seed register write
  input  logic                        seed_we_i,
  input  logic [mtg_pkg::WORD_W-1:0]  seed_wdata_i,
  // requests
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [mtg_pkg::DRAW_W-1:0]  s_axis_tdata_i,   // [0] draw, [7:1] zero
  // results
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [mtg_pkg::WORD_W-1:0]  m_axis_tdata_o    // [31:0] random_word
);

  localparam int unsigned IdxW = $clog2(StateWords);

  localparam logic ST_FILL = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic            state_q, state_d;
  logic [IdxW-1:0] fill_idx_q, fill_idx_d;
  mtg_pkg::word_t  seed_q;
  logic            out_valid_q, out_valid_d;
  mtg_pkg::word_t  out_data_q;

  logic           accept;
  logic           draw;
  logic           take;
  logic           shift_en;
  logic           fill_last;
  mtg_pkg::word_t tail_d;
  mtg_pkg::word_t fill_word;
  mtg_pkg::word_t twist_word;
  mtg_pkg::word_t temper_word;
  mtg_pkg::word_t chain_w [StateWords];

  // Handshake decode
  assign s_axis_tready_o = (state_q == ST_RUN) && (!out_valid_q || m_axis_tready_i);
  assign accept    = s_axis_tvalid_i && s_axis_tready_o;
  assign draw      = accept && s_axis_tdata_i[0];
  assign take      = out_valid_q && m_axis_tready_i;
  assign fill_last = (fill_idx_q == IdxW'(StateWords - 1));
  assign shift_en  = (state_q == ST_FILL) || draw;
  assign tail_d    = (state_q == ST_FILL) ? fill_word : twist_word;

  // Chain of state cells; cell 0 is the oldest word, new words enter at the tail
  for (genvar g = 0; g < StateWords; g++) begin : g_cell
    if (g == StateWords - 1) begin : g_tail
      mtg_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (shift_en),
        .word_i  (tail_d),
        .word_o  (chain_w[g])
      );
    end else begin : g_body
      mtg_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (shift_en),
        .word_i  (chain_w[g+1]),
        .word_o  (chain_w[g])
      );
    end
  end

  mtg_seed #(
    .IdxW (IdxW)
  ) u_seed (
    .seed_i (seed_q),
    .prev_i (chain_w[StateWords-1]),
    .idx_i  (fill_idx_q),
    .fill_o (fill_word)
  );

  mtg_twist u_twist (
    .head_i   (chain_w[0]),
    .next_i   (chain_w[1]),
    .tap_i    (chain_w[TapOffset]),
    .word_o   (twist_word),
    .temper_o (temper_word)
  );

  // Fill sequencer; a seed write restarts the fill
  always_comb begin
    state_d    = state_q;
    fill_idx_d = fill_idx_q;
    unique case (state_q)
      ST_FILL: begin
        if (fill_last) begin
          state_d    = ST_RUN;
          fill_idx_d = '0;
        end else begin
          fill_idx_d = fill_idx_q + 1'b1;
        end
      end
      ST_RUN: begin
        state_d = ST_RUN;
      end
      default: begin
        state_d = ST_FILL;
      end
    endcase
    if (seed_we_i) begin
      state_d    = ST_FILL;
      fill_idx_d = '0;
    end
  end

  // Output valid
  assign out_valid_d = (out_valid_q && !take) || draw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      fill_idx_q  <= '0;
      seed_q      <= mtg_pkg::SEED_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_idx_q  <= fill_idx_d;
      out_valid_q <= out_valid_d;
      if (seed_we_i) begin
        seed_q <= seed_wdata_i;
      end
    end
  end

  // Output word
  always_ff @(posedge clk_i) begin
    if (draw) begin
      out_data_q <= temper_word;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

`ifndef SYNTHESIS
  // No request is taken while the chain is being filled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> (state_q == ST_RUN))
    else $error("request taken during fill");

  // A draw always leaves a word in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    draw |=> m_axis_tvalid_o)
    else $error("draw produced no output word");

  // A seed write restarts the fill from the first word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seed_we_i |=> (state_q == ST_FILL) && (fill_idx_q == '0))
    else $error("seed write did not restart fill");

  // Fill counter rests at zero in run mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (fill_idx_q == '0))
    else $error("fill counter not idle in run mode");
`endif

endmodule
